[sv/rbac_pkg.sv]
`timescale 1ns / 1ps
// Package for the role-based access check: payload types, codes and the rule function.
// No dependencies; used by role_based_access_check.

package rbac_pkg;

   // Role table geometry
   localparam int ROLE_ENTRIES = 16;
   localparam int IDX_W        = (ROLE_ENTRIES > 1) ? $clog2(ROLE_ENTRIES) : 1;
   localparam int CNT_W        = $clog2(ROLE_ENTRIES + 1);

   // Transaction function codes
   localparam logic FUNC_SET_ROLE = 1'b0;
   localparam logic FUNC_CHECK    = 1'b1;

   // Role codes
   localparam logic [2:0] ROLE_KERNEL = 3'd0;
   localparam logic [2:0] ROLE_DBA    = 3'd1;
   localparam logic [2:0] ROLE_APP    = 3'd2;
   localparam logic [2:0] ROLE_ANON   = 3'd3;

   // Object kinds
   localparam logic [2:0] KIND_SYS_META  = 3'd0;
   localparam logic [2:0] KIND_DB_TABLE  = 3'd1;
   localparam logic [2:0] KIND_DB_INDEX  = 3'd2;
   localparam logic [2:0] KIND_HEAP_BLOB = 3'd3;

   // Permission bits
   localparam logic [7:0] ACC_RD = 8'h01;
   localparam logic [7:0] ACC_WR = 8'h02;
   localparam logic [7:0] ACC_EX = 8'h04;

   // Set-role status codes
   localparam logic STATUS_STORED = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] uid;
      logic [2:0]  role_code;
      logic        object_found;
      logic [31:0] obj_owner;
      logic [2:0]  object_kind;
      logic [7:0]  object_perms;
      logic [7:0]  wanted_perms;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic [2:0] effective_role;
      logic       status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] uid;
      logic [2:0]  role;
   } entry_type;

   // Access rules, first match wins
   function automatic logic decide(
      input logic [2:0] role,
      input logic       is_owner,
      input logic       found,
      input logic [2:0] kind,
      input logic [7:0] have,
      input logic [7:0] want
   );
      logic grant;
      grant = 1'b0;
      if (role == ROLE_KERNEL) begin
         grant = 1'b1;
      end else if (!found) begin
         grant = 1'b0;
      end else if (is_owner) begin
         grant = 1'b1;
      end else if (role == ROLE_DBA &&
                   (kind == KIND_DB_TABLE || kind == KIND_DB_INDEX)) begin
         grant = 1'b1;
      end else if (role == ROLE_APP && kind == KIND_DB_TABLE &&
                   (want & ACC_RD) != 8'h00) begin
         grant = ((want & (ACC_WR | ACC_EX)) == 8'h00);
      end else if (role == ROLE_ANON) begin
         grant = (kind == KIND_HEAP_BLOB && want == ACC_RD);
      end else begin
         grant = ((have & want) == want);
      end
      return grant;
   endfunction

endpackage

[sv/role_based_access_check.sv]
`timescale 1ns / 1ps
// Role-based access check: uid-to-role table in a synchronous memory, scanned per transaction.
// Depends on rbac_pkg.
//
// Transactions are handled one at a time: req_stall holds off a new request until the
// result of the last one is posted. The single memory read port walks every table entry
// once per transaction, with one comparator behind it.
// Reset: synchronous; clears the valid bits and the control state. Table contents stay
// undefined until written and are never used while their valid bit is clear.

module role_based_access_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rbac_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rbac_pkg::rsp_type rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   localparam int                    N_ENT   = rbac_pkg::ROLE_ENTRIES;
   localparam int                    IDX_W   = rbac_pkg::IDX_W;
   localparam int                    CNT_W   = rbac_pkg::CNT_W;
   localparam logic [CNT_W-1:0]      CNT_END = CNT_W'(N_ENT);

   // Control and status registers
   state_type             state_ff,     state_in;
   logic [N_ENT-1:0]      valid_ff,     valid_in;
   logic [CNT_W-1:0]      rd_cnt_ff,    rd_cnt_in;
   logic                  rd_pend_ff,   rd_pend_in;
   logic [IDX_W-1:0]      rd_idx_ff,    rd_idx_in;
   logic                  hit_ff,       hit_in;
   logic [IDX_W-1:0]      hit_idx_ff,   hit_idx_in;
   logic [2:0]            hit_role_ff,  hit_role_in;
   logic                  free_ff,      free_in;
   logic [IDX_W-1:0]      free_idx_ff,  free_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers
   rbac_pkg::req_type     item_ff,      item_in;
   rbac_pkg::rsp_type     rsp_ff,       rsp_in;

   // Role table memory and its read register
   rbac_pkg::entry_type   role_mem [N_ENT];
   rbac_pkg::entry_type   rd_entry_ff;
   logic                  mem_rd_en;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   rbac_pkg::entry_type   mem_wr_data;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  entry_match;
   logic                  slot_ok;
   logic [IDX_W-1:0]      slot_idx;
   logic [2:0]            eff_role;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Compare the entry read last cycle against the uid of the transaction in hand
   assign entry_match = rd_pend_ff && valid_ff[rd_idx_ff] && (rd_entry_ff.uid == item_ff.uid);

   // Update the matching entry, else take the lowest free one
   assign slot_ok  = hit_ff || free_ff;
   assign slot_idx = hit_ff ? hit_idx_ff : free_idx_ff;

   // Uid zero is always kernel; an unknown uid is a guest
   assign eff_role = (item_ff.uid == 32'd0) ? rbac_pkg::ROLE_KERNEL :
                     hit_ff                 ? hit_role_ff          : rbac_pkg::ROLE_ANON;

   // Post the result once the output register is free
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // The read for the next transaction only starts after the write-back, so the
   // state machine itself is the interlock on same-entry accesses.
   assign mem_rd_en   = (state_ff == ST_SCAN) && (rd_cnt_ff != CNT_END);
   assign mem_rd_addr = rd_cnt_ff[IDX_W-1:0];
   assign mem_wr_en   = rsp_load && (item_ff.func == rbac_pkg::FUNC_SET_ROLE) && slot_ok;
   assign mem_wr_addr = slot_idx;
   assign mem_wr_data = '{uid: item_ff.uid, role: item_ff.role_code};

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_pend_in   = rd_pend_ff;
      rd_idx_in    = rd_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_role_in  = hit_role_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in    = req_payload;
               rd_cnt_in  = '0;
               rd_pend_in = 1'b0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue the next read
            rd_pend_in = mem_rd_en;
            if (mem_rd_en) begin
               rd_idx_in = mem_rd_addr;
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            end
            // Keep the lowest match and the lowest free slot
            if (entry_match && !hit_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = rd_idx_ff;
               hit_role_in = rd_entry_ff.role;
            end
            if (rd_pend_ff && !valid_ff[rd_idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = rd_idx_ff;
            end
            // Last compare lands in this edge
            if (rd_pend_ff && rd_cnt_ff == CNT_END) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               if (item_ff.func == rbac_pkg::FUNC_SET_ROLE) begin
                  rsp_in.allowed        = 1'b0;
                  rsp_in.effective_role = 3'd0;
                  rsp_in.status         = slot_ok ? rbac_pkg::STATUS_STORED
                                                  : rbac_pkg::STATUS_FULL;
                  if (slot_ok) begin
                     valid_in[slot_idx] = 1'b1;
                  end
               end else begin
                  rsp_in.allowed        = rbac_pkg::decide(eff_role,
                                             item_ff.obj_owner == item_ff.uid,
                                             item_ff.object_found, item_ff.object_kind,
                                             item_ff.object_perms, item_ff.wanted_perms);
                  rsp_in.effective_role = eff_role;
                  rsp_in.status         = rbac_pkg::STATUS_STORED;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rd_cnt_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_role_ff <= hit_role_in;
      free_idx_ff <= free_idx_in;
      item_ff     <= item_in;
      rsp_ff      <= rsp_in;
   end

   // Role table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         role_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_entry_ff <= role_mem[mem_rd_addr];
      end
   end

   // Valid bits only ever get set
   a_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      (valid_ff & $past(valid_ff)) == $past(valid_ff))
      else $error("role table valid bit dropped");

   // A full report only when every slot is taken and nothing matched
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && item_ff.func == rbac_pkg::FUNC_SET_ROLE && !slot_ok) |-> (&valid_ff))
      else $error("table full reported with a free slot");

   // The scan has covered the whole table before a result is formed
   a_scan_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (rd_cnt_ff == CNT_END && !rd_pend_ff))
      else $error("result formed before the table scan finished");

   // A written slot is marked valid on the next cycle
   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> valid_ff[$past(mem_wr_addr)])
      else $error("written table entry not marked valid");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for role_based_access_check: directed and random transactions, checked by a scoreboard.
// Depends on rbac_pkg and role_based_access_check.

module testbench;

   // Generous ceiling on the run, in clock cycles
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int          RANDOM_ITEMS  = 1600;
   localparam int          POOL_SIZE     = 24;
   // Sets how long the receiver holds off when asked for a long back-pressure stretch
   localparam int          HOLD_OFF_CYC  = 300;
   // Margin after the last response, longer than one transaction takes in the block
   localparam int          SETTLE_CYC    = 40;

   // Scoreboard: keeps its own copy of the role table, predicts each
   // response and checks the block's responses in order.
   class access_scoreboard;
      logic [31:0]       uid_of [rbac_pkg::ROLE_ENTRIES];
      logic [2:0]        role_of[rbac_pkg::ROLE_ENTRIES];
      bit                in_use [rbac_pkg::ROLE_ENTRIES];
      rbac_pkg::rsp_type awaited[$];
      int unsigned       errors;

      function new();
         foreach (in_use[i]) in_use[i] = 1'b0;
         errors = 0;
      endfunction

      // Lowest live entry holding this uid, or -1
      function int find_entry(logic [31:0] who);
         for (int i = 0; i < rbac_pkg::ROLE_ENTRIES; i++) begin
            if (in_use[i] && uid_of[i] == who) return i;
         end
         return -1;
      endfunction

      // Access rules in priority order; first match decides
      function logic grant_for(logic [2:0] role, rbac_pkg::req_type r);
         if (role == rbac_pkg::ROLE_KERNEL) return 1'b1;
         if (!r.object_found) return 1'b0;
         if (r.obj_owner == r.uid) return 1'b1;
         case (role)
            rbac_pkg::ROLE_DBA: begin
               if (r.object_kind == rbac_pkg::KIND_DB_TABLE ||
                   r.object_kind == rbac_pkg::KIND_DB_INDEX)
                  return 1'b1;
            end
            rbac_pkg::ROLE_APP: begin
               if (r.object_kind == rbac_pkg::KIND_DB_TABLE &&
                   (r.wanted_perms & rbac_pkg::ACC_RD) != 8'h00)
                  return (r.wanted_perms & (rbac_pkg::ACC_WR | rbac_pkg::ACC_EX)) == 8'h00;
            end
            rbac_pkg::ROLE_ANON: begin
               return r.object_kind == rbac_pkg::KIND_HEAP_BLOB &&
                      r.wanted_perms == rbac_pkg::ACC_RD;
            end
            default: ;
         endcase
         return (r.object_perms & r.wanted_perms) == r.wanted_perms;
      endfunction

      // Update the table copy and queue the response this transaction causes
      function void note_request(rbac_pkg::req_type r);
         rbac_pkg::rsp_type outcome;
         int                slot;
         logic [2:0]        role;
         outcome = '0;
         slot = find_entry(r.uid);
         if (r.func == rbac_pkg::FUNC_SET_ROLE) begin
            if (slot < 0) begin
               for (int i = rbac_pkg::ROLE_ENTRIES - 1; i >= 0; i--) begin
                  if (!in_use[i]) slot = i;
               end
            end
            if (slot >= 0) begin
               uid_of[slot]  = r.uid;
               role_of[slot] = r.role_code;
               in_use[slot]  = 1'b1;
               outcome.status = rbac_pkg::STATUS_STORED;
            end else begin
               outcome.status = rbac_pkg::STATUS_FULL;
            end
         end else begin
            if (r.uid == 32'd0) role = rbac_pkg::ROLE_KERNEL;
            else if (slot >= 0) role = role_of[slot];
            else role = rbac_pkg::ROLE_ANON;
            outcome.effective_role = role;
            outcome.allowed        = grant_for(role, r);
            outcome.status         = rbac_pkg::STATUS_STORED;
         end
         awaited.push_back(outcome);
      endfunction

      // Compare one response, field by field, with the oldest prediction
      function void check_response(rbac_pkg::rsp_type got);
         rbac_pkg::rsp_type want_rsp;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: response with nothing outstanding: got %p", $time, got);
            return;
         end
         want_rsp = awaited.pop_front();
         if (got.allowed !== want_rsp.allowed) begin
            errors++;
            $display("%0t: allowed mismatch: expected %0d got %0d",
                     $time, want_rsp.allowed, got.allowed);
         end
         if (got.effective_role !== want_rsp.effective_role) begin
            errors++;
            $display("%0t: effective_role mismatch: expected %0d got %0d",
                     $time, want_rsp.effective_role, got.effective_role);
         end
         if (got.status !== want_rsp.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d got %0d",
                     $time, want_rsp.status, got.status);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   rbac_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   rbac_pkg::rsp_type rsp_payload;

   access_scoreboard sb = new();

   // uids that recur often, so that entries get updated and the table fills
   logic [31:0] uid_pool[POOL_SIZE];

   // Long hold-off requests from the sender side, served by the receiver
   int hold_requests = 0;
   int hold_served   = 0;

   role_based_access_check dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one transaction from the falling edge and hold it until accepted.
   // Returns just after the accepting rising edge, with valid still high.
   task automatic send(input rbac_pkg::req_type item);
      @(negedge clock);
      req_valid   = 1'b1;
      req_payload = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(item);
   endtask

   // Drop valid and keep it low for the idle time given by n
   task automatic idle_for(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // Set-role transaction; the object fields are don't-care, so randomise them
   function automatic rbac_pkg::req_type set_role_item(logic [31:0] who, logic [2:0] role);
      rbac_pkg::req_type r;
      r.func         = rbac_pkg::FUNC_SET_ROLE;
      r.uid          = who;
      r.role_code    = role;
      r.object_found = 1'($urandom);
      r.obj_owner    = $urandom;
      r.object_kind  = 3'($urandom);
      r.object_perms = 8'($urandom);
      r.wanted_perms = 8'($urandom);
      return r;
   endfunction

   function automatic rbac_pkg::req_type check_item(logic [31:0] who, logic found,
                                                    logic [31:0] owner, logic [2:0] kind,
                                                    logic [7:0] have, logic [7:0] want);
      rbac_pkg::req_type r;
      r.func         = rbac_pkg::FUNC_CHECK;
      r.uid          = who;
      r.role_code    = 3'($urandom);
      r.object_found = found;
      r.obj_owner    = owner;
      r.object_kind  = kind;
      r.object_perms = have;
      r.wanted_perms = want;
      return r;
   endfunction

   function automatic logic [31:0] pick_uid();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return uid_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Random transaction: mostly pooled uids, roles biased to the named ones,
   // and wanted masks that often hit the exact-read and subset cases
   function automatic rbac_pkg::req_type random_transaction();
      rbac_pkg::req_type r;
      logic [2:0]        role;
      logic [2:0]        kind;
      logic [31:0]       owner;
      logic [7:0]        want;
      r = '0;
      if ($urandom_range(0, 9) < 3) begin
         role = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(1, 3)) : 3'($urandom);
         r = set_role_item(pick_uid(), role);
      end else begin
         r.uid = pick_uid();
         case ($urandom_range(0, 2))
            0:       owner = r.uid;
            1:       owner = uid_pool[$urandom_range(0, POOL_SIZE - 1)];
            default: owner = $urandom;
         endcase
         kind = ($urandom_range(0, 9) < 6) ? 3'($urandom_range(1, 3)) : 3'($urandom);
         r = check_item(r.uid, $urandom_range(0, 19) < 17, owner, kind, 8'($urandom), 8'h00);
         case ($urandom_range(0, 5))
            0:       want = rbac_pkg::ACC_RD;
            1, 2:    want = 8'($urandom_range(0, 7));
            3:       want = r.object_perms & 8'($urandom);
            default: want = 8'($urandom);
         endcase
         r.wanted_perms = want;
      end
      return r;
   endfunction

   // Sender: reset, directed transactions, then random bursts
   initial begin
      rbac_pkg::req_type directed[$];
      int                burst_left;
      req_valid   = 1'b0;
      req_payload = '0;
      reset       = 1'b1;
      burst_left  = 0;

      uid_pool[0] = 32'd0;
      uid_pool[1] = 32'hFFFF_FFFF;
      uid_pool[2] = 32'd5;
      uid_pool[3] = 32'd7;
      uid_pool[4] = 32'd9;
      for (int i = 5; i < POOL_SIZE; i++) uid_pool[i] = $urandom;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table: kernel, guest and owner rules
      directed.push_back(check_item(32'd0, 1'b0, 32'd1, rbac_pkg::KIND_SYS_META,
                                    8'h00, 8'hFF));
      directed.push_back(check_item(32'd5, 1'b1, 32'd6, rbac_pkg::KIND_HEAP_BLOB, 8'h00,
                                    rbac_pkg::ACC_RD));
      directed.push_back(check_item(32'd5, 1'b1, 32'd6, rbac_pkg::KIND_HEAP_BLOB, 8'hFF,
                                    rbac_pkg::ACC_RD | rbac_pkg::ACC_WR));
      directed.push_back(check_item(32'd5, 1'b1, 32'd6, rbac_pkg::KIND_DB_TABLE, 8'hFF,
                                    rbac_pkg::ACC_RD));
      directed.push_back(check_item(32'd5, 1'b1, 32'd5, rbac_pkg::KIND_SYS_META,
                                    8'h00, 8'hFF));
      directed.push_back(check_item(32'd5, 1'b0, 32'd5, rbac_pkg::KIND_HEAP_BLOB, 8'hFF,
                                    rbac_pkg::ACC_RD));
      // uid zero stored in the table, yet still resolved as kernel
      directed.push_back(set_role_item(32'd0, rbac_pkg::ROLE_ANON));
      directed.push_back(check_item(32'd0, 1'b0, 32'd1, 3'd7, 8'h00, 8'hFF));
      // Database admin on the all-ones uid
      directed.push_back(set_role_item(32'hFFFF_FFFF, rbac_pkg::ROLE_DBA));
      directed.push_back(check_item(32'hFFFF_FFFF, 1'b1, 32'd0, rbac_pkg::KIND_DB_TABLE,
                                    8'h00, 8'hFF));
      directed.push_back(check_item(32'hFFFF_FFFF, 1'b1, 32'd0, rbac_pkg::KIND_DB_INDEX,
                                    8'h00, 8'hFF));
      directed.push_back(check_item(32'hFFFF_FFFF, 1'b1, 32'd0, rbac_pkg::KIND_SYS_META,
                                    8'h05, 8'h07));
      // App user: read-only on a table, otherwise the object mask
      directed.push_back(set_role_item(32'd7, rbac_pkg::ROLE_APP));
      directed.push_back(check_item(32'd7, 1'b1, 32'd8, rbac_pkg::KIND_DB_TABLE, 8'h00,
                                    rbac_pkg::ACC_RD));
      directed.push_back(check_item(32'd7, 1'b1, 32'd8, rbac_pkg::KIND_DB_TABLE, 8'hFF,
                                    rbac_pkg::ACC_RD | rbac_pkg::ACC_EX));
      directed.push_back(check_item(32'd7, 1'b1, 32'd8, rbac_pkg::KIND_DB_TABLE, 8'hF0,
                                    8'h80));
      directed.push_back(check_item(32'd7, 1'b1, 32'd8, rbac_pkg::KIND_DB_INDEX, 8'h00,
                                    rbac_pkg::ACC_RD));
      // Update to an unnamed role: falls through to the mask
      directed.push_back(set_role_item(32'd7, 3'd5));
      directed.push_back(check_item(32'd7, 1'b1, 32'd8, 3'd6, 8'hFF, 8'hFF));
      directed.push_back(check_item(32'd7, 1'b1, 32'd8, rbac_pkg::KIND_HEAP_BLOB, 8'h00,
                                    rbac_pkg::ACC_RD));
      // Stored kernel role grants even a missing object
      directed.push_back(set_role_item(32'd9, 3'd7));
      directed.push_back(set_role_item(32'd9, rbac_pkg::ROLE_KERNEL));
      directed.push_back(check_item(32'd9, 1'b0, 32'd1, 3'd4, 8'h00, 8'hFF));
      directed.push_back(check_item(32'hFFFF_FFFE, 1'b1, 32'd1, rbac_pkg::KIND_DB_TABLE,
                                    8'hFF, rbac_pkg::ACC_RD));

      foreach (directed[i]) send(directed[i]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Ask the receiver for a long hold-off so the block backs up
         if (i == 300 || i == 1100) hold_requests++;
         // Pause and let every outstanding response drain
         if (i == 700) begin
            idle_for(1);
            while (sb.pending() != 0) @(posedge clock);
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // Hold back-to-back through one stretch, otherwise gap between bursts
            if (!(i >= 900 && i < 1000)) idle_for($urandom_range(1, 12));
         end
         burst_left--;
         send(random_transaction());
      end

      idle_for(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Receiver: stall on a pattern whose mode is redrawn at random when cyc_in_mode wraps,
   // and serve long hold-offs when the sender asks for them
   initial begin
      int mode;
      int cyc_in_mode;
      int stall_run;
      rsp_stall   = 1'b0;
      mode        = 0;
      cyc_in_mode = 0;
      stall_run   = 0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_stall = 1'b1;
            for (int n = 1; n < HOLD_OFF_CYC; n++) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            cyc_in_mode++;
            if (cyc_in_mode == 150) begin
               cyc_in_mode = 0;
               mode = $urandom_range(0, 3);
            end
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 2) == 0);
               2: rsp_stall = ((cyc_in_mode % 5) < 2);
               default: begin
                  if (stall_run > 0) begin
                     stall_run--;
                     rsp_stall = 1'b1;
                  end else if ($urandom_range(0, 19) == 0) begin
                     stall_run = $urandom_range(5, 30);
                     rsp_stall = 1'b1;
                  end else begin
                     rsp_stall = 1'b0;
                  end
               end
            endcase
         end
      end
   end

   // Check every accepted response at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
   end

   // Watchdog
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
sv/rbac_pkg.sv
sv/role_based_access_check.sv
test/testbench.sv
